>>> rtl/sdem_pkg.sv
// ----------------------------------------------------------------------------
// sdem_pkg
// Shared types, constants and helper functions of the sparse duplicate
// entry merger.
// ----------------------------------------------------------------------------
package sdem_pkg;

    // Block geometry and field widths.
    localparam int MAX_DOF   = 7;
    localparam int ROW_BITS  = 24;
    localparam int VAL_BITS  = 32;
    localparam int CNT_BITS  = 32;
    localparam int BLK_DEPTH = MAX_DOF * MAX_DOF;
    localparam int ADDR_BITS = $clog2(BLK_DEPTH);
    localparam int ELEM_BITS = $clog2(BLK_DEPTH + 1);
    localparam int DOF_BITS  = 3;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_DOF  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INDEX_BASE = 1'b1;

    // Command queue between front and back.
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    // What follows the element write of a command.
    typedef enum logic [1:0] {
        POST_NONE,
        POST_FLUSH,
        POST_MARK
    } t_post;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE_FLUSH,
        ST_ELEM_WR,
        ST_POST_START,
        ST_POST_FLUSH,
        ST_POST_MARK
    } t_state;

    // One classified item as handed from the front to the back.
    typedef struct packed {
        logic                 pre_flush;
        logic                 has_elem;
        logic                 acc;
        logic [ADDR_BITS-1:0] elem_idx;
        logic [VAL_BITS-1:0]  re;
        logic [VAL_BITS-1:0]  im;
        t_post                post;
        logic [ROW_BITS-1:0]  pre_row;
        logic [ROW_BITS-1:0]  post_row;
        logic [CNT_BITS-1:0]  pre_ptr;
        logic [CNT_BITS-1:0]  post_ptr;
        logic [CNT_BITS-1:0]  merge;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [VAL_BITS-1:0] re;
        logic [VAL_BITS-1:0] im;
        logic                has_value;
        logic                column_done;
        logic [CNT_BITS-1:0] column_pointer;
        logic [CNT_BITS-1:0] merge_total;
        logic                last;
    } t_result;

    // Settings the back needs from the configuration registers.
    typedef struct packed {
        logic [ELEM_BITS-1:0] elems;
    } t_cfg;

    // Number of elements of one entry, with the dof clamped to 1..MAX_DOF.
    function automatic logic [ELEM_BITS-1:0] elems_per_entry(
        input logic [DOF_BITS-1:0] dof
    );
        logic [DOF_BITS-1:0]  d;
        logic [ELEM_BITS-1:0] dw;
        d = dof;
        if (d == '0) begin
            d = DOF_BITS'(1);
        end
        if (d > DOF_BITS'(MAX_DOF)) begin
            d = DOF_BITS'(MAX_DOF);
        end
        dw = ELEM_BITS'(d);
        return ELEM_BITS'(dw * dw);
    endfunction

    // Signed add with saturation to the value range.
    function automatic logic [VAL_BITS-1:0] sat_add(
        input logic [VAL_BITS-1:0] a,
        input logic [VAL_BITS-1:0] b
    );
        logic [VAL_BITS:0] s;
        s = {a[VAL_BITS-1], a} + {b[VAL_BITS-1], b};
        if (s[VAL_BITS] != s[VAL_BITS-1]) begin
            return s[VAL_BITS] ? {1'b1, {(VAL_BITS-1){1'b0}}}
                               : {1'b0, {(VAL_BITS-1){1'b1}}};
        end
        return s[VAL_BITS-1:0];
    endfunction

endpackage

>>> rtl/sdem_ram.sv
// ----------------------------------------------------------------------------
// sdem_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module sdem_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 49
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/sdem_front.sv
// ----------------------------------------------------------------------------
// sdem_front
// Accepts items, tracks the held entry, the position inside the current
// entry and the counters, and turns each item into one command.
// ----------------------------------------------------------------------------
module sdem_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sdem_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [sdem_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_q_full,
    input  logic                                 i_action,
    input  logic [sdem_pkg::ROW_BITS-1:0]        i_row_index,
    input  logic [sdem_pkg::VAL_BITS-1:0]        i_value_re,
    input  logic [sdem_pkg::VAL_BITS-1:0]        i_value_im,
    input  logic                                 i_column_end,
    output logic                                 o_push,
    output sdem_pkg::t_cmd                       o_cmd,
    output sdem_pkg::t_cfg                       o_cfg
);

    logic [sdem_pkg::DOF_BITS-1:0]  r_dof;
    logic                           r_base;
    logic                           r_pv;
    logic [sdem_pkg::ROW_BITS-1:0]  r_prow;
    logic [sdem_pkg::ELEM_BITS-1:0] r_ctr;
    logic                           r_acc;
    logic [sdem_pkg::CNT_BITS-1:0]  r_ptr;
    logic [sdem_pkg::CNT_BITS-1:0]  r_merged;

    logic                           n_pv;
    logic [sdem_pkg::ROW_BITS-1:0]  n_prow;
    logic [sdem_pkg::ELEM_BITS-1:0] n_ctr;
    logic                           n_acc;
    logic [sdem_pkg::CNT_BITS-1:0]  n_ptr;
    logic [sdem_pkg::CNT_BITS-1:0]  n_merged;

    logic [sdem_pkg::ELEM_BITS-1:0] elems;
    logic [sdem_pkg::ELEM_BITS-1:0] ctr;
    logic [sdem_pkg::ELEM_BITS-1:0] ctr1;
    logic                           start;
    logic                           match;
    logic                           pre;
    logic                           pv_b;
    logic                           complete;
    logic                           post_flush;
    logic [1:0]                     flushes;

    assign elems  = sdem_pkg::elems_per_entry(r_dof);
    assign o_cfg  = '{elems: elems};
    assign o_push = i_in_valid && !i_q_full;

    // Classification of the item against the held entry.
    always_comb begin
        ctr      = (r_ctr >= elems) ? '0 : r_ctr;
        ctr1     = ctr + 1'b1;
        start    = (ctr == '0);
        match    = !i_action && start && r_pv && (i_row_index == r_prow);
        pre      = i_action ? r_pv : (start && r_pv && !match);
        complete = !i_action && (ctr1 >= elems);
        pv_b     = complete || (r_pv && !pre);
        post_flush = !i_action && i_column_end && pv_b;
        flushes  = {1'b0, pre} + {1'b0, post_flush};
    end

    // Command for the back and next state.
    always_comb begin
        n_prow   = (!i_action && start && !match) ? i_row_index : r_prow;
        n_merged = r_merged + sdem_pkg::CNT_BITS'(match);
        n_ptr    = r_ptr + sdem_pkg::CNT_BITS'(flushes);

        o_cmd.pre_flush = pre;
        o_cmd.has_elem  = !i_action;
        o_cmd.acc       = start ? match : r_acc;
        o_cmd.elem_idx  = sdem_pkg::ADDR_BITS'(ctr);
        o_cmd.re        = i_value_re;
        o_cmd.im        = i_value_im;
        o_cmd.pre_row   = r_prow;
        o_cmd.post_row  = n_prow;
        o_cmd.pre_ptr   = r_ptr + sdem_pkg::CNT_BITS'(pre);
        o_cmd.post_ptr  = n_ptr;
        o_cmd.merge     = n_merged;

        if (i_action) begin
            o_cmd.post = sdem_pkg::POST_MARK;
            n_pv  = 1'b0;
            n_ctr = '0;
            n_acc = 1'b0;
        end else begin
            if (!i_column_end) begin
                o_cmd.post = sdem_pkg::POST_NONE;
            end else if (post_flush) begin
                o_cmd.post = sdem_pkg::POST_FLUSH;
            end else begin
                o_cmd.post = sdem_pkg::POST_MARK;
            end
            n_pv  = pv_b && !i_column_end;
            n_ctr = (complete || i_column_end) ? '0 : ctr1;
            n_acc = (complete || i_column_end) ? 1'b0 : o_cmd.acc;
        end
    end

    // State registers; configuration writes take priority.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dof    <= sdem_pkg::DOF_BITS'(1);
            r_base   <= 1'b0;
            r_pv     <= 1'b0;
            r_prow   <= '0;
            r_ctr    <= '0;
            r_acc    <= 1'b0;
            r_ptr    <= '0;
            r_merged <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdem_pkg::REG_BLOCK_DOF: begin
                    r_dof <= i_cfg_data[sdem_pkg::DOF_BITS-1:0];
                    r_pv  <= 1'b0;
                    r_ctr <= '0;
                    r_acc <= 1'b0;
                end
                sdem_pkg::REG_INDEX_BASE: begin
                    r_base <= i_cfg_data[0];
                    r_ptr  <= r_ptr - sdem_pkg::CNT_BITS'(r_base)
                                    + sdem_pkg::CNT_BITS'(i_cfg_data[0]);
                end
                default: begin
                end
            endcase
        end else if (o_push) begin
            r_pv     <= n_pv;
            r_prow   <= n_prow;
            r_ctr    <= n_ctr;
            r_acc    <= n_acc;
            r_ptr    <= n_ptr;
            r_merged <= n_merged;
        end
    end

endmodule

>>> rtl/sdem_queue.sv
// ----------------------------------------------------------------------------
// sdem_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module sdem_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sdem_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output sdem_pkg::t_cmd o_head
);

    sdem_pkg::t_cmd                r_mem [sdem_pkg::Q_DEPTH];
    logic [sdem_pkg::Q_PTR_BITS-1:0] r_wptr;
    logic [sdem_pkg::Q_PTR_BITS-1:0] r_rptr;
    logic [sdem_pkg::Q_PTR_BITS:0]   r_count;

    assign o_full  = (r_count == (sdem_pkg::Q_PTR_BITS+1)'(sdem_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (sdem_pkg::Q_PTR_BITS+1)'(i_push)
                               - (sdem_pkg::Q_PTR_BITS+1)'(i_pop);
        end
    end

endmodule

>>> rtl/sdem_back.sv
// ----------------------------------------------------------------------------
// sdem_back
// Carries out commands: writes or accumulates block elements in the block
// memory, streams held entries out and issues column markers.
// ----------------------------------------------------------------------------
module sdem_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sdem_pkg::t_cfg      i_cfg,
    input  logic                i_q_valid,
    input  sdem_pkg::t_cmd      i_q_head,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output sdem_pkg::t_result   o_out
);

    localparam int RAM_W = 2 * sdem_pkg::VAL_BITS;

    sdem_pkg::t_state r_state;
    sdem_pkg::t_state n_state;
    sdem_pkg::t_cmd   r_cmd;
    logic [sdem_pkg::ADDR_BITS-1:0] r_idx;
    logic [sdem_pkg::ADDR_BITS-1:0] n_idx;
    logic              r_out_valid;
    sdem_pkg::t_result r_out;
    sdem_pkg::t_result n_out;
    logic              load;

    logic                           rd_en;
    logic [sdem_pkg::ADDR_BITS-1:0] rd_addr;
    logic [RAM_W-1:0]               rd_data;
    logic                           wr_en;
    logic [sdem_pkg::ADDR_BITS-1:0] wr_addr;
    logic [RAM_W-1:0]               wr_data;

    logic                           out_free;
    logic [sdem_pkg::ELEM_BITS-1:0] idx1;
    logic                           final_elem;
    logic [sdem_pkg::VAL_BITS-1:0]  rd_re;
    logic [sdem_pkg::VAL_BITS-1:0]  rd_im;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign idx1       = sdem_pkg::ELEM_BITS'(r_idx) + 1'b1;
    assign final_elem = (idx1 >= i_cfg.elems);
    assign rd_re      = rd_data[RAM_W-1:sdem_pkg::VAL_BITS];
    assign rd_im      = rd_data[sdem_pkg::VAL_BITS-1:0];

    // Block memory holding the real and imaginary parts side by side.
    sdem_ram #(
        .WIDTH(RAM_W),
        .DEPTH(sdem_pkg::BLK_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // Where a command goes once its element is written.
    function automatic sdem_pkg::t_state post_state(input sdem_pkg::t_post p);
        case (p)
            sdem_pkg::POST_FLUSH: return sdem_pkg::ST_POST_START;
            sdem_pkg::POST_MARK:  return sdem_pkg::ST_POST_MARK;
            default:              return sdem_pkg::ST_IDLE;
        endcase
    endfunction

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sdem_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_head.pre_flush) begin
                        n_state = sdem_pkg::ST_PRE_FLUSH;
                    end else if (i_q_head.has_elem && i_q_head.acc) begin
                        n_state = sdem_pkg::ST_ELEM_WR;
                    end else begin
                        n_state = post_state(i_q_head.post);
                    end
                end
            end
            sdem_pkg::ST_PRE_FLUSH: begin
                if (out_free && final_elem) begin
                    n_state = r_cmd.has_elem ? sdem_pkg::ST_ELEM_WR
                                             : post_state(r_cmd.post);
                end
            end
            sdem_pkg::ST_ELEM_WR: begin
                n_state = post_state(r_cmd.post);
            end
            sdem_pkg::ST_POST_START: begin
                n_state = sdem_pkg::ST_POST_FLUSH;
            end
            sdem_pkg::ST_POST_FLUSH: begin
                if (out_free && final_elem) begin
                    n_state = sdem_pkg::ST_IDLE;
                end
            end
            sdem_pkg::ST_POST_MARK: begin
                if (out_free) begin
                    n_state = sdem_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdem_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory accesses, queue pop and result formation.
    always_comb begin
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_cmd.elem_idx;
        wr_data = {r_cmd.re, r_cmd.im};
        n_idx   = r_idx;
        load    = 1'b0;

        n_out.row            = '0;
        n_out.re             = '0;
        n_out.im             = '0;
        n_out.has_value      = 1'b0;
        n_out.column_done    = 1'b1;
        n_out.column_pointer = r_cmd.post_ptr;
        n_out.merge_total    = r_cmd.merge;
        n_out.last           = 1'b1;

        case (r_state)
            sdem_pkg::ST_IDLE: begin
                o_pop = i_q_valid;
                if (i_q_valid) begin
                    if (i_q_head.pre_flush) begin
                        rd_en = 1'b1;
                        n_idx = '0;
                    end else if (i_q_head.has_elem) begin
                        if (i_q_head.acc) begin
                            rd_en   = 1'b1;
                            rd_addr = i_q_head.elem_idx;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = i_q_head.elem_idx;
                            wr_data = {i_q_head.re, i_q_head.im};
                        end
                    end
                end
            end
            sdem_pkg::ST_PRE_FLUSH,
            sdem_pkg::ST_POST_FLUSH: begin
                n_out.re        = rd_re;
                n_out.im        = rd_im;
                n_out.has_value = 1'b1;
                if (r_state == sdem_pkg::ST_PRE_FLUSH) begin
                    n_out.row            = r_cmd.pre_row;
                    n_out.column_pointer = r_cmd.pre_ptr;
                    n_out.column_done    = 1'b0;
                    n_out.last = final_elem && (r_cmd.post == sdem_pkg::POST_NONE);
                end else begin
                    n_out.row         = r_cmd.post_row;
                    n_out.column_done = final_elem;
                    n_out.last        = final_elem;
                end
                if (out_free) begin
                    load = 1'b1;
                    if (!final_elem) begin
                        rd_en   = 1'b1;
                        rd_addr = sdem_pkg::ADDR_BITS'(idx1);
                        n_idx   = sdem_pkg::ADDR_BITS'(idx1);
                    end
                end
            end
            sdem_pkg::ST_ELEM_WR: begin
                wr_en = 1'b1;
                if (r_cmd.acc) begin
                    wr_data = {sdem_pkg::sat_add(rd_re, r_cmd.re),
                               sdem_pkg::sat_add(rd_im, r_cmd.im)};
                end
            end
            sdem_pkg::ST_POST_START: begin
                rd_en = 1'b1;
                n_idx = '0;
            end
            sdem_pkg::ST_POST_MARK: begin
                load = out_free;
            end
            default: begin
            end
        endcase
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdem_pkg::ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command and result payload registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_head;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/sparse_duplicate_entry_merger.sv
// ----------------------------------------------------------------------------
// sparse_duplicate_entry_merger
// Each accepted item becomes a command in the command queue; the back-end sequencer
// pops it and registers any results it causes into the output register. A held-entry
// flush streams one result a cycle while the output is not stalled.
// Reset: synchronous, active low; clears counters, the held entry and queue.
// ----------------------------------------------------------------------------
module sparse_duplicate_entry_merger (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sdem_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [sdem_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_action,
    input  logic [sdem_pkg::ROW_BITS-1:0]      i_row_index,
    input  logic signed [sdem_pkg::VAL_BITS-1:0] i_value_re,
    input  logic signed [sdem_pkg::VAL_BITS-1:0] i_value_im,
    input  logic                               i_column_end,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [sdem_pkg::ROW_BITS-1:0]      o_out_row,
    output logic signed [sdem_pkg::VAL_BITS-1:0] o_out_re,
    output logic signed [sdem_pkg::VAL_BITS-1:0] o_out_im,
    output logic                               o_has_value,
    output logic                               o_column_done,
    output logic [sdem_pkg::CNT_BITS-1:0]      o_column_pointer,
    output logic [sdem_pkg::CNT_BITS-1:0]      o_merge_total,
    output logic                               o_last
);

    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              pop;
    sdem_pkg::t_cmd    cmd;
    sdem_pkg::t_cmd    head;
    sdem_pkg::t_cfg    cfg;
    sdem_pkg::t_result res;

    assign o_in_stall = q_full;

    // Item classification.
    sdem_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_q_full    (q_full),
        .i_action    (i_action),
        .i_row_index (i_row_index),
        .i_value_re  (i_value_re),
        .i_value_im  (i_value_im),
        .i_column_end(i_column_end),
        .o_push      (push),
        .o_cmd       (cmd),
        .o_cfg       (cfg)
    );

    // Command queue.
    sdem_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_head (head)
    );

    // Block memory and result sequencing.
    sdem_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_q_valid  (q_valid),
        .i_q_head   (head),
        .o_pop      (pop),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out      (res)
    );

    assign o_out_row        = res.row;
    assign o_out_re         = res.re;
    assign o_out_im         = res.im;
    assign o_has_value      = res.has_value;
    assign o_column_done    = res.column_done;
    assign o_column_pointer = res.column_pointer;
    assign o_merge_total    = res.merge_total;
    assign o_last           = res.last;

endmodule

>>> rtl/sdem_checker.sv
// ----------------------------------------------------------------------------
// sdem_checker
// Port-level checks of the result stream of the duplicate entry merger.
// ----------------------------------------------------------------------------
module sdem_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [sdem_pkg::ROW_BITS-1:0] o_out_row,
    input logic [sdem_pkg::VAL_BITS-1:0] o_out_re,
    input logic [sdem_pkg::VAL_BITS-1:0] o_out_im,
    input logic                          o_has_value,
    input logic                          o_column_done,
    input logic                          o_last
);

    // A stalled result stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_re)
            && $stable(o_out_row) && $stable(o_last))
        else $error("stalled result changed");

    // A result without a value is always a column close and ends its item.
    a_novalue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_value |-> o_column_done && o_last
            && o_out_row == '0 && o_out_re == '0 && o_out_im == '0)
        else $error("malformed result without value");

    // Closing a column is always the final result of an item.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_column_done |-> o_last)
        else $error("column closed before last result");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sparse_duplicate_entry_merger sdem_checker u_sdem_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_row    (o_out_row),
    .o_out_re     (o_out_re),
    .o_out_im     (o_out_im),
    .o_has_value  (o_has_value),
    .o_column_done(o_column_done),
    .o_last       (o_last)
);

>>> bench/sparse_duplicate_entry_merger_tb.sv
// ----------------------------------------------------------------------------
// sparse_duplicate_entry_merger_tb
// Streams value elements of compressed-column entries into the merger and
// checks every result item against a local prediction of the merge. A short
// table of directed items comes first, then random columns under several
// block sizes and index bases, with random gaps on both channels.
// ----------------------------------------------------------------------------
module sparse_duplicate_entry_merger_tb;

    localparam int MAX_DOF       = sdem_pkg::MAX_DOF;
    localparam int ROW_BITS      = sdem_pkg::ROW_BITS;
    localparam int VAL_BITS      = sdem_pkg::VAL_BITS;
    localparam int CNT_BITS      = sdem_pkg::CNT_BITS;
    localparam int BLK_DEPTH     = sdem_pkg::BLK_DEPTH;
    localparam int DOF_BITS      = sdem_pkg::DOF_BITS;
    localparam int CFG_IDX_BITS  = sdem_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS = sdem_pkg::CFG_DATA_BITS;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_DOF  = sdem_pkg::REG_BLOCK_DOF;
    localparam logic [CFG_IDX_BITS-1:0] REG_INDEX_BASE = sdem_pkg::REG_INDEX_BASE;

    typedef sdem_pkg::t_result t_result;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int PREDICTED     = -1;
    localparam int NUM_PHASES    = 5;
    localparam longint SAT_HI    = 64'sd2147483647;
    localparam longint SAT_LO    = -64'sd2147483648;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // One input item as the block sees it.
    typedef struct packed {
        logic                action;
        logic [ROW_BITS-1:0] row;
        logic [VAL_BITS-1:0] re;
        logic [VAL_BITS-1:0] im;
        logic                col_end;
    } t_elem;

    // One row of the directed table.
    typedef struct {
        t_row_kind                kind;
        logic [CFG_IDX_BITS-1:0]  cfg_idx;
        logic [CFG_DATA_BITS-1:0] cfg_val;
        t_elem                    item;
        int                       n_exp;
        t_result                  want;
    } t_stim_row;

    // Ports of the block.
    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_BITS-1:0]    i_cfg_index;
    logic [CFG_DATA_BITS-1:0]   i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_action;
    logic [ROW_BITS-1:0]        i_row_index;
    logic signed [VAL_BITS-1:0] i_value_re;
    logic signed [VAL_BITS-1:0] i_value_im;
    logic                       i_column_end;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [ROW_BITS-1:0]        o_out_row;
    logic signed [VAL_BITS-1:0] o_out_re;
    logic signed [VAL_BITS-1:0] o_out_im;
    logic                       o_has_value;
    logic                       o_column_done;
    logic [CNT_BITS-1:0]        o_column_pointer;
    logic [CNT_BITS-1:0]        o_merge_total;
    logic                       o_last;

    // Predicted state of the merger.
    logic [DOF_BITS-1:0] cur_dof;
    logic                cur_base;
    logic [ROW_BITS-1:0] held_row;
    bit                  held_valid;
    logic [VAL_BITS-1:0] sum_re [BLK_DEPTH];
    logic [VAL_BITS-1:0] sum_im [BLK_DEPTH];
    int unsigned         fill_pos;
    bit                  folding;
    logic [CNT_BITS-1:0] kept_total;
    logic [CNT_BITS-1:0] folded_total;

    // Results of the item in hand, and all results still to come.
    t_result   step_out[$];
    t_result   merged_out_q[$];
    t_stim_row directed_rows[$];

    bit      tx_idle_on;
    bit      rx_idle_on;
    int      rx_wait = 0;
    int      idle_cycles = 0;
    int      error_count = 0;
    int      phase_items;
    t_result head_result;

    sparse_duplicate_entry_merger dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_row_index      (i_row_index),
        .i_value_re       (i_value_re),
        .i_value_im       (i_value_im),
        .i_column_end     (i_column_end),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_row        (o_out_row),
        .o_out_re         (o_out_re),
        .o_out_im         (o_out_im),
        .o_has_value      (o_has_value),
        .o_column_done    (o_column_done),
        .o_column_pointer (o_column_pointer),
        .o_merge_total    (o_merge_total),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Elements per entry, with a zero dof treated as one.
    function automatic int unsigned block_len();
        int unsigned d;
        d = (cur_dof == '0) ? 1 : cur_dof;
        if (d > MAX_DOF) begin
            d = MAX_DOF;
        end
        return d * d;
    endfunction

    // Signed sum clamped to the 32-bit range.
    function automatic logic [VAL_BITS-1:0] clamp_sum(input logic [VAL_BITS-1:0] a,
                                                      input logic [VAL_BITS-1:0] b);
        longint s;
        s = longint'($signed(a)) + longint'($signed(b));
        if (s > SAT_HI) begin
            s = SAT_HI;
        end
        if (s < SAT_LO) begin
            s = SAT_LO;
        end
        return s[VAL_BITS-1:0];
    endfunction

    // Appends one predicted result; value fields read zero without a value.
    function automatic void emit_result(input logic [ROW_BITS-1:0] row,
                                        input logic [VAL_BITS-1:0] re,
                                        input logic [VAL_BITS-1:0] im,
                                        input logic has, input logic done);
        t_result r;
        r.row            = has ? row : '0;
        r.re             = has ? re : '0;
        r.im             = has ? im : '0;
        r.has_value      = has;
        r.column_done    = done;
        r.column_pointer = CNT_BITS'(cur_base) + kept_total;
        r.merge_total    = folded_total;
        r.last           = 1'b0;
        step_out.push_back(r);
    endfunction

    // Sends out the held entry, closing the column on its last element if asked.
    function automatic void flush_held(input bit close);
        int unsigned n;
        n = block_len();
        kept_total = kept_total + 1'b1;
        for (int unsigned i = 0; i < n; i++) begin
            emit_result(held_row, sum_re[i], sum_im[i], 1'b1, close && (i + 1 == n));
        end
        held_valid = 1'b0;
    endfunction

    // Ends whatever entry is open; tells whether the held entry closed the column.
    function automatic bit close_open(input bit close);
        bit closed;
        closed = 1'b0;
        if (held_valid) begin
            flush_held(close);
            closed = close;
        end
        held_valid = 1'b0;
        fill_pos   = 0;
        folding    = 1'b0;
        return closed;
    endfunction

    // Works out the results that one accepted item causes, into step_out.
    function automatic void predict_merge(input t_elem it);
        int unsigned n;
        int unsigned e;
        bit          closed;
        t_result     r;
        step_out.delete();
        n = block_len();
        if (it.action) begin
            closed = close_open(1'b0);
            emit_result('0, '0, '0, 1'b0, 1'b1);
        end else begin
            if (fill_pos >= n) begin
                fill_pos = 0;
            end
            // The first element of an entry decides between merge and a fresh entry.
            if (fill_pos == 0) begin
                if (held_valid && it.row == held_row) begin
                    folding      = 1'b1;
                    folded_total = folded_total + 1'b1;
                end else begin
                    if (held_valid) begin
                        flush_held(1'b0);
                    end
                    folding  = 1'b0;
                    held_row = it.row;
                end
            end
            e = fill_pos;
            if (folding) begin
                sum_re[e] = clamp_sum(sum_re[e], it.re);
                sum_im[e] = clamp_sum(sum_im[e], it.im);
            end else begin
                sum_re[e] = it.re;
                sum_im[e] = it.im;
            end
            fill_pos = e + 1;
            if (fill_pos >= n) begin
                fill_pos   = 0;
                folding    = 1'b0;
                held_valid = 1'b1;
            end
            if (it.col_end) begin
                closed = close_open(1'b1);
                if (!closed) begin
                    emit_result('0, '0, '0, 1'b0, 1'b1);
                end
            end
        end
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
    endfunction

    function automatic t_result typed_result(input logic [ROW_BITS-1:0] row,
                                             input logic [VAL_BITS-1:0] re,
                                             input logic [VAL_BITS-1:0] im,
                                             input logic has, input logic done,
                                             input logic [CNT_BITS-1:0] ptr,
                                             input logic [CNT_BITS-1:0] merges);
        t_result r;
        r.row            = row;
        r.re             = re;
        r.im             = im;
        r.has_value      = has;
        r.column_done    = done;
        r.column_pointer = ptr;
        r.merge_total    = merges;
        r.last           = 1'b1;
        return r;
    endfunction

    function automatic void add_item(input logic act, input logic [ROW_BITS-1:0] row,
                                     input logic [VAL_BITS-1:0] re,
                                     input logic [VAL_BITS-1:0] im, input logic ce,
                                     input int n_exp, input t_result want);
        t_stim_row s;
        s.kind    = ROW_ITEM;
        s.cfg_idx = '0;
        s.cfg_val = '0;
        s.item    = '{action: act, row: row, re: re, im: im, col_end: ce};
        s.n_exp   = n_exp;
        s.want    = want;
        directed_rows.push_back(s);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] val);
        t_stim_row s;
        s.kind    = ROW_CFG;
        s.cfg_idx = idx;
        s.cfg_val = val;
        s.item    = '0;
        s.n_exp   = PREDICTED;
        s.want    = '0;
        directed_rows.push_back(s);
    endfunction

    // Values lean on the saturation points and on small magnitudes.
    function automatic logic [VAL_BITS-1:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return VAL_BITS'($urandom_range(0, 32'h3_FFFF));
            3: return 32'h0 - VAL_BITS'($urandom_range(0, 32'h3_FFFF));
            default: return VAL_BITS'($urandom);
        endcase
    endfunction

    function automatic t_elem rand_item();
        t_elem it;
        it.action  = 1'($urandom_range(0, 1));
        it.row     = ROW_BITS'($urandom);
        it.re      = rand_val();
        it.im      = rand_val();
        it.col_end = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic flag_mismatch(input string what, input logic [CNT_BITS-1:0] got,
                                 input logic [CNT_BITS-1:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    // Writes one register while the block is idle and mirrors it in the prediction.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_BLOCK_DOF) begin
            cur_dof    = val;
            held_valid = 1'b0;
            fill_pos   = 0;
            folding    = 1'b0;
        end else begin
            cur_base = val[0];
        end
    endtask

    // Offers one item after a random gap and returns at the edge that takes it.
    task automatic send_item(input t_elem it);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= it.action;
        i_row_index  <= it.row;
        i_value_re   <= it.re;
        i_value_im   <= it.im;
        i_column_end <= it.col_end;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
    endtask

    task automatic issue(input t_elem it);
        send_item(it);
        predict_merge(it);
        foreach (step_out[i]) begin
            merged_out_q.push_back(step_out[i]);
        end
        phase_items++;
    endtask

    // Holds the sender off until every result is in and the block has gone quiet.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (merged_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One column of entries: mostly well formed, with duplicate rows, stray
    // empty-column markers and the odd column that ends inside an entry.
    task automatic gen_column();
        int unsigned         n;
        int unsigned         entries;
        int unsigned         cut;
        logic [ROW_BITS-1:0] row;
        t_elem               it;
        n       = block_len();
        entries = $urandom_range(1, (n > 9) ? 1 : ((n > 4) ? 2 : 4));
        row     = ROW_BITS'($urandom);
        for (int unsigned k = 0; k < entries; k++) begin
            if (k > 0 && $urandom_range(0, 1) == 0) begin
                row = row + ROW_BITS'($urandom_range(1, 4));
            end
            if ($urandom_range(0, 9) == 0) begin
                it = rand_item();
                it.action = 1'b1;
                issue(it);
            end
            cut = n;
            if (n > 1 && $urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, n - 1);
            end
            for (int unsigned j = 0; j < cut; j++) begin
                it.action  = 1'b0;
                it.row     = (j == 0) ? row : ROW_BITS'($urandom);
                it.re      = rand_val();
                it.im      = rand_val();
                it.col_end = (cut < n) ? (j == cut - 1) : (k == entries - 1 && j == n - 1);
                issue(it);
            end
            if (cut < n) begin
                break;
            end
        end
    endtask

    // Result checking and receiver stalls.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (merged_out_q.size() == 0) begin
                flag_mismatch("result with nothing expected", CNT_BITS'(o_out_row), '0);
            end else begin
                head_result = merged_out_q.pop_front();
                if (o_out_row !== head_result.row)
                    flag_mismatch("out_row", CNT_BITS'(o_out_row), CNT_BITS'(head_result.row));
                if (o_out_re !== head_result.re)
                    flag_mismatch("out_re", o_out_re, head_result.re);
                if (o_out_im !== head_result.im)
                    flag_mismatch("out_im", o_out_im, head_result.im);
                if (o_has_value !== head_result.has_value)
                    flag_mismatch("has_value", CNT_BITS'(o_has_value),
                                  CNT_BITS'(head_result.has_value));
                if (o_column_done !== head_result.column_done)
                    flag_mismatch("column_done", CNT_BITS'(o_column_done),
                                  CNT_BITS'(head_result.column_done));
                if (o_column_pointer !== head_result.column_pointer)
                    flag_mismatch("column_pointer", o_column_pointer,
                                  head_result.column_pointer);
                if (o_merge_total !== head_result.merge_total)
                    flag_mismatch("merge_total", o_merge_total, head_result.merge_total);
                if (o_last !== head_result.last)
                    flag_mismatch("last", CNT_BITS'(o_last), CNT_BITS'(head_result.last));
            end
            rx_wait = rx_idle_on ? $urandom_range(0, 5) : 0;
        end
        if (rx_wait > 0) begin
            i_out_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("sparse_duplicate_entry_merger_tb: done, errors");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        int unsigned ph_dof [NUM_PHASES];
        int unsigned ph_base [NUM_PHASES];
        int unsigned ph_budget [NUM_PHASES];
        t_stim_row   srow;
        bit          paused;

        ph_dof    = '{1, 2, 0, 3, 7};
        ph_base   = '{1, 0, 0, 1, 0};
        ph_budget = '{8, 10, 6, 1, 1};
        paused    = 1'b0;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_action     <= 1'b0;
        i_row_index  <= '0;
        i_value_re   <= '0;
        i_value_im   <= '0;
        i_column_end <= 1'b0;

        // Prediction starts from the reset state.
        cur_dof      = DOF_BITS'(1);
        cur_base     = 1'b0;
        held_row     = '0;
        held_valid   = 1'b0;
        fill_pos     = 0;
        folding      = 1'b0;
        kept_total   = '0;
        folded_total = '0;
        foreach (sum_re[i]) begin
            sum_re[i] = '0;
            sum_im[i] = '0;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // Directed table, block size one and base zero after reset.
        add_item(1'b1, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1,
                 typed_result('0, '0, '0, 1'b0, 1'b1, 32'd0, 32'd0));
        add_item(1'b0, 24'h00_0005, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1,
                 typed_result(24'h00_0005, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1,
                              32'd1, 32'd0));
        add_item(1'b0, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0, '0);
        // A duplicate row pinned at both saturation limits.
        add_item(1'b0, 24'hFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1,
                 typed_result(24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1,
                              32'd2, 32'd1));
        add_item(1'b0, 24'h00_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, '0);
        add_item(1'b0, 24'h00_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, '0);
        // Empty-column marker while an entry is held.
        add_item(1'b1, 24'h00_0000, 32'h0, 32'h0, 1'b0, PREDICTED, '0);
        add_cfg(REG_INDEX_BASE, CFG_DATA_BITS'(1));
        add_item(1'b1, 24'h12_3456, 32'h0001_0000, 32'hFFFF_0000, 1'b1, 1,
                 typed_result('0, '0, '0, 1'b0, 1'b1, 32'd4, 32'd2));
        add_cfg(REG_BLOCK_DOF, CFG_DATA_BITS'(2));
        add_item(1'b0, 24'h00_0003, 32'h0001_0000, 32'h0000_8000, 1'b0, PREDICTED, '0);
        add_item(1'b0, 24'hAB_CDEF, 32'hFFFF_0000, 32'h7FFF_0000, 1'b0, PREDICTED, '0);
        add_item(1'b0, 24'h00_0000, 32'h7FFF_FFFF, 32'h8000_0001, 1'b0, PREDICTED, '0);
        add_item(1'b0, 24'hFF_FFFF, 32'h0000_0001, 32'h0000_0002, 1'b0, PREDICTED, '0);
        // Column ends inside an entry that is being merged.
        add_item(1'b0, 24'h00_0003, 32'h0002_0000, 32'h0001_8000, 1'b0, PREDICTED, '0);
        add_item(1'b0, 24'h55_5555, 32'h8000_0000, 32'h0100_0000, 1'b1, PREDICTED, '0);
        add_item(1'b0, 24'h00_0007, 32'h0000_1234, 32'h0000_4321, 1'b0, PREDICTED, '0);
        add_item(1'b0, 24'h00_0000, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0, PREDICTED, '0);
        add_item(1'b0, 24'h00_0000, 32'h0BAD_F00D, 32'h8765_4321, 1'b0, PREDICTED, '0);
        add_item(1'b0, 24'h00_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, PREDICTED, '0);
        // Rewriting the dof drops the held entry, and a zero dof acts as one.
        add_cfg(REG_BLOCK_DOF, CFG_DATA_BITS'(0));
        add_item(1'b0, 24'h00_0007, 32'h0000_0100, 32'h0000_0200, 1'b1, PREDICTED, '0);
        add_cfg(REG_BLOCK_DOF, CFG_DATA_BITS'(2));
        add_item(1'b0, 24'h00_0009, 32'h7000_0000, 32'h9000_0000, 1'b0, PREDICTED, '0);
        add_item(1'b0, 24'h00_0000, 32'h0000_0010, 32'h0000_0020, 1'b0, PREDICTED, '0);
        add_item(1'b0, 24'h00_0000, 32'h0000_0030, 32'h0000_0040, 1'b0, PREDICTED, '0);
        add_item(1'b0, 24'h00_0000, 32'h0000_0050, 32'h0000_0060, 1'b0, PREDICTED, '0);
        // Marker with a merge in progress, then a column ending in a fresh entry.
        add_item(1'b0, 24'h00_0009, 32'h7000_0000, 32'h9000_0000, 1'b0, PREDICTED, '0);
        add_item(1'b1, 24'h00_0009, 32'h0, 32'h0, 1'b0, PREDICTED, '0);
        add_item(1'b0, 24'h00_0004, 32'h0000_0001, 32'h0000_0001, 1'b1, PREDICTED, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table.
        foreach (directed_rows[k]) begin
            srow = directed_rows[k];
            if (srow.kind == ROW_CFG) begin
                drain_results();
                write_reg(srow.cfg_idx, srow.cfg_val);
            end else if (srow.n_exp == PREDICTED) begin
                issue(srow.item);
            end else begin
                send_item(srow.item);
                predict_merge(srow.item);
                if (srow.n_exp == 1) begin
                    merged_out_q.push_back(srow.want);
                end
            end
        end

        // Random columns under each register setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_reg(REG_BLOCK_DOF, CFG_DATA_BITS'(ph_dof[p]));
            write_reg(REG_INDEX_BASE,
                      CFG_DATA_BITS'({$urandom_range(0, 3), 1'(ph_base[p])}));
            if (p == 0) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else if (p == 1) begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end else begin
                tx_idle_on = 1'($urandom_range(0, 1));
                rx_idle_on = 1'($urandom_range(0, 1));
            end
            phase_items = 0;
            while (phase_items < ph_budget[p]) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 2)) issue(rand_item());
                end
                gen_column();
                // Once in mid stream, let every pending result come out.
                if (p == 1 && !paused && phase_items * 2 >= ph_budget[p]) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        if (error_count == 0) begin
            $display("sparse_duplicate_entry_merger_tb: done, clean");
        end else begin
            $display("sparse_duplicate_entry_merger_tb: done, errors");
        end
        $finish;
    end

endmodule
